// ===== hw/rtl/emfp_pkg.sv =====
// ----------------------------------------------------------------------------
// emfp_pkg
// Types and constants shared by the meter frame parser modules.
// ----------------------------------------------------------------------------
package emfp_pkg;

   localparam int FrameLen = 24;
   localparam int StoreLen = FrameLen - 1;   // bytes 0..22 held, byte 23 arrives live
   localparam int PosWidth = 5;

   localparam logic [7:0] SYNC_BYTE = 8'h5A;
   localparam logic [PosWidth-1:0] FIRST_BODY_POS = PosWidth'(2);
   localparam logic [PosWidth-1:0] CHECK_POS = PosWidth'(FrameLen - 1);

   localparam int FLAG_OVFL_BIT = 7;
   localparam int FLAG_VOLT_BIT = 6;
   localparam int FLAG_CURR_BIT = 5;
   localparam int FLAG_POWR_BIT = 4;

   typedef logic [StoreLen-1:0][7:0] frame_bytes_type;

   typedef struct packed {
      logic at_check;   // next item is the checksum byte
      logic done;       // checksum byte accepted this cycle
      logic good;       // checksum matched
   } framer_status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  header_byte;
      logic [23:0] voltage_param;
      logic [23:0] voltage_reg;
      logic [23:0] current_param;
      logic [23:0] current_reg;
      logic [23:0] power_param;
      logic [23:0] power_reg;
      logic [7:0]  flag_byte;
      logic [15:0] pulse_count;
      logic [15:0] pulse_overflows;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/emfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// emfp_stream_if
// Valid/ready item channel with a typed payload.
// ----------------------------------------------------------------------------
interface emfp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/emfp_framer.sv =====
// ----------------------------------------------------------------------------
// emfp_framer
// Sync hunt, frame byte shift store and running checksum.
// ----------------------------------------------------------------------------
module emfp_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  rx_byte,
   output emfp_pkg::framer_status_type status,
   output emfp_pkg::frame_bytes_type   frame
);
   import emfp_pkg::*;

   localparam logic [1:0] PHASE_FIRST   = 2'd0;
   localparam logic [1:0] PHASE_SYNC    = 2'd1;
   localparam logic [1:0] PHASE_COLLECT = 2'd2;

   logic [1:0]          phase_ff, phase_in;
   logic [7:0]          prev_ff, prev_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [7:0]          sum_ff, sum_in;
   frame_bytes_type     frame_ff, frame_in;
   logic                at_check;

   assign at_check = (phase_ff == PHASE_COLLECT) && (pos_ff == CHECK_POS);

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      frame_in = frame_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_SYNC: begin
               if (rx_byte == SYNC_BYTE) begin
                  frame_in[StoreLen-2] = prev_ff;
                  frame_in[StoreLen-1] = rx_byte;
                  pos_in   = FIRST_BODY_POS;
                  sum_in   = '0;
                  phase_in = PHASE_COLLECT;
               end else begin
                  prev_in = rx_byte;
               end
            end
            PHASE_COLLECT: begin
               if (pos_ff < FIRST_BODY_POS || pos_ff >= CHECK_POS) begin
                  phase_in = PHASE_FIRST;
                  pos_in   = '0;
               end else begin
                  frame_in = {rx_byte, frame_ff[StoreLen-1:1]};
                  sum_in   = sum_ff + rx_byte;
                  pos_in   = pos_ff + PosWidth'(1);
               end
            end
            default: begin
               prev_in  = rx_byte;
               phase_in = PHASE_SYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         prev_ff  <= '0;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign status.at_check = at_check;
   assign status.done     = accept && at_check;
   assign status.good     = (sum_ff == rx_byte);
   assign frame           = frame_ff;

endmodule

// ===== hw/rtl/emfp_result.sv =====
// ----------------------------------------------------------------------------
// emfp_result
// Field extraction, overflow counter and result register.
// ----------------------------------------------------------------------------
module emfp_result (
   input  logic                        clock,
   input  logic                        reset,
   input  emfp_pkg::framer_status_type status,
   input  emfp_pkg::frame_bytes_type   frame,
   output logic                        out_free,
   emfp_stream_if.source               rsp
);
   import emfp_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type payload_ff, payload_in;
   logic [15:0]     ovfl_ff, ovfl_in;
   logic [7:0]      flags;
   logic            emit;

   assign flags    = frame[20];
   assign emit     = status.done && status.good;
   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      ovfl_in = ovfl_ff;
      if (emit && flags[FLAG_OVFL_BIT]) begin
         ovfl_in = ovfl_ff + 16'd1;
      end
   end

   always_comb begin
      payload_in                 = payload_ff;
      payload_in.header_byte     = frame[0];
      payload_in.voltage_param   = {frame[2], frame[3], frame[4]};
      payload_in.voltage_reg     = flags[FLAG_VOLT_BIT] ? {frame[5], frame[6], frame[7]} : '0;
      payload_in.current_param   = {frame[8], frame[9], frame[10]};
      payload_in.current_reg     = flags[FLAG_CURR_BIT] ? {frame[11], frame[12], frame[13]} : '0;
      payload_in.power_param     = {frame[14], frame[15], frame[16]};
      payload_in.power_reg       = flags[FLAG_POWR_BIT] ? {frame[17], frame[18], frame[19]} : '0;
      payload_in.flag_byte       = flags;
      payload_in.pulse_count     = {frame[21], frame[22]};
      payload_in.pulse_overflows = ovfl_in;
   end

   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ovfl_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         ovfl_ff  <= ovfl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = payload_ff;

endmodule

// ===== hw/rtl/energy_meter_frame_parser_core.sv =====
// Takes one received byte per cycle (req) and emits one result item (rsp) for each
// 24-byte meter frame whose sum of bytes 2..22 modulo 256 equals byte 23. The result
// appears in the cycle after the checksum byte is taken, from a single output register.
// Input is always ready except on the checksum byte while an earlier result is still
// unread, so the rate is one byte per cycle whenever results are drained.
// ----------------------------------------------------------------------------
// energy_meter_frame_parser_core
// Top level: byte channel in, parsed frame items out.
// ----------------------------------------------------------------------------
module energy_meter_frame_parser_core (
   input  logic          clock,
   input  logic          reset,
   emfp_stream_if.sink   req,
   emfp_stream_if.source rsp
);
   import emfp_pkg::*;

   framer_status_type status;
   frame_bytes_type   frame;
   logic              out_free;
   logic              accept;

   assign req.ready = !status.at_check || out_free;
   assign accept    = req.valid && req.ready;

   emfp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req.payload.rx_byte),
      .status  (status),
      .frame   (frame)
   );

   emfp_result u_result (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .frame    (frame),
      .out_free (out_free),
      .rsp      (rsp)
   );

   a_done_has_room: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp.valid || rsp.ready))
      else $error("checksum item taken while result register is occupied");

   a_good_frame_emits: assert property (@(posedge clock) disable iff (reset)
      (status.done && status.good) |=> rsp.valid)
      else $error("good frame did not produce a result");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(status.done && status.good))
      else $error("result appeared without a good frame");

endmodule
